// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: hdl/lcbs_pkg.sv
// ----------------------------------------------------------------------------
// lcbs_pkg
// Types and constants of the LED chain bit serializer.
// ----------------------------------------------------------------------------
package lcbs_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TICK_W   = 8;
   localparam int unsigned BITS_W   = 4;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MSB_FIRST = 3'd4;

   // register reset values
   localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd4;
   localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd9;
   localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd8;
   localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd6;
   localparam logic              MSB_FIRST_RST = 1'b0;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic byte_accepted;
      logic busy_res;
   } rsp_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic              offer;
      logic [BYTE_W-1:0] pixel;
   } tick_cmd_type;

   // handshake between front and back
   typedef struct packed {
      logic         valid;
      tick_cmd_type cmd;
   } cmd_chan_type;

endpackage

// File: hdl/led_chain_bit_serializer_unit.sv
// ----------------------------------------------------------------------------
// led_chain_bit_serializer_unit
// Serializes pixel bytes onto a single-wire LED data line, one tick per word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | req_data (mode, pixel_byte)
//  rsp     | out | rsp_valid/rsp_ready   | rsp_data (line_level, byte_accepted,
//          |     |                       |           busy_res)
//  csr     | in  | csr_we                | csr_index, csr_wdata
//
// The back's tick engine runs one tick and retires one queued word per cycle
// while no result stalls. An accepted word waits in the front queue until the
// back takes it and registers its result. Reset clears the queue and line
// state and restores the timing registers. A stalled result holds the back;
// the front queue of QUEUE_DEPTH words keeps req_ready high until it fills.
// ----------------------------------------------------------------------------
module led_chain_bit_serializer_unit
   import lcbs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   cmd_chan_type cmd_chan;
   logic         cmd_ready;

   lcbs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_out   (cmd_chan),
      .cmd_ready (cmd_ready)
   );

   lcbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd_chan),
      .cmd_ready (cmd_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/lcbs_front.sv
// ----------------------------------------------------------------------------
// lcbs_front
// Accepts request words, classifies them into tick commands and queues them.
// ----------------------------------------------------------------------------
module lcbs_front
   import lcbs_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output cmd_chan_type cmd_out,
   input  logic         cmd_ready
);

`include "assert_macros.svh"

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tick_cmd_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   tick_cmd_type           cmd_new;
   logic                   push, pop;

   // drop the byte of a plain tick so the back never sees stale data
   always_comb begin
      cmd_new.offer = req_data.mode;
      cmd_new.pixel = req_data.mode ? req_data.pixel_byte : '0;
   end

   assign req_ready     = (count_ff != CNT_W'(DEPTH));
   assign cmd_out.valid = (count_ff != '0);
   assign cmd_out.cmd   = entries_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = cmd_out.valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH))
   `ASSERT_PROP(a_count_rise, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

// File: hdl/lcbs_back.sv
// ----------------------------------------------------------------------------
// lcbs_back
// Runs one line tick per command: holding register, bit shifter, phase timer.
// ----------------------------------------------------------------------------
module lcbs_back
   import lcbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_chan_type         cmd_in,
   output logic                 cmd_ready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

`include "assert_macros.svh"

   logic [TICK_W-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic              msb_first_ff;

   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic              high_phase_ff, high_phase_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              advance;
   logic              cur_bit;
   logic [TICK_W-1:0] dur;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = cmd_in.valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZERO_HIGH_RST;
         zero_low_ff  <= ZERO_LOW_RST;
         one_high_ff  <= ONE_HIGH_RST;
         one_low_ff   <= ONE_LOW_RST;
         msb_first_ff <= MSB_FIRST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata;
            CSR_ZERO_LOW:  zero_low_ff  <= csr_wdata;
            CSR_ONE_HIGH:  one_high_ff  <= csr_wdata;
            CSR_ONE_LOW:   one_low_ff   <= csr_wdata;
            CSR_MSB_FIRST: msb_first_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      bits_left_in  = bits_left_ff;
      high_phase_in = high_phase_ff;
      tick_count_in = tick_count_ff;
      rsp_data_in   = '0;

      if (cmd_in.cmd.offer && !held_valid_in) begin
         held_byte_in              = cmd_in.cmd.pixel;
         held_valid_in             = 1'b1;
         rsp_data_in.byte_accepted = 1'b1;
      end
      // idle with a byte waiting: start it in this same tick
      if (bits_left_in == '0 && held_valid_in) begin
         shift_in      = held_byte_in;
         held_valid_in = 1'b0;
         bits_left_in  = BYTE_BITS;
         high_phase_in = 1'b1;
         tick_count_in = '0;
      end

      rsp_data_in.busy_res = (bits_left_in != '0) || held_valid_in;

      cur_bit = msb_first_ff ? shift_in[BYTE_W-1] : shift_in[0];
      if (high_phase_in) begin
         dur = cur_bit ? one_high_ff : zero_high_ff;
      end else begin
         dur = cur_bit ? one_low_ff : zero_low_ff;
      end

      if (bits_left_in != '0) begin
         rsp_data_in.line_level = high_phase_in;
         // a zero duration also ends the phase after one tick
         if ({1'b0, tick_count_in} + 9'd1 >= {1'b0, dur}) begin
            tick_count_in = '0;
            if (high_phase_in) begin
               high_phase_in = 1'b0;
            end else begin
               shift_in = msb_first_ff ? {shift_in[BYTE_W-2:0], 1'b0}
                                       : {1'b0, shift_in[BYTE_W-1:1]};
               bits_left_in = bits_left_in - 1'b1;
               if (bits_left_in == '0) begin
                  high_phase_in = 1'b0;
                  // chain the held byte with no gap
                  if (held_valid_in) begin
                     shift_in      = held_byte_in;
                     held_valid_in = 1'b0;
                     bits_left_in  = BYTE_BITS;
                     high_phase_in = 1'b1;
                     tick_count_in = '0;
                  end
               end else begin
                  high_phase_in = 1'b1;
               end
            end
         end else begin
            tick_count_in = tick_count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         bits_left_ff  <= '0;
         high_phase_ff <= 1'b0;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            shift_ff      <= shift_in;
            held_byte_ff  <= held_byte_in;
            held_valid_ff <= held_valid_in;
            bits_left_ff  <= bits_left_in;
            high_phase_ff <= high_phase_in;
            tick_count_ff <= tick_count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `ASSERT_NEVER(a_bits_bound, clock, reset, bits_left_ff > BYTE_BITS)
   `ASSERT_NEVER(a_high_needs_byte, clock, reset, high_phase_ff && (bits_left_ff == '0))
   `ASSERT_NEVER(a_idle_not_held, clock, reset, (bits_left_ff == '0) && held_valid_ff)

endmodule
